@@ rtl/core/trb_pkg.sv @@
// Shared types and constants for the triangle bounding-box rasterizer.
`default_nettype none

package trb_pkg;

  localparam int WIDTH_BITS = 11;
  localparam int SHADE_BITS = 24;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 11'd256;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/trb_edge.sv @@
// Edge-function sign test of one pixel against one triangle edge.
`default_nettype none

module trb_edge #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  output logic                         neg
);

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;

  logic signed [DIFF_BITS-1:0] dpx;
  logic signed [DIFF_BITS-1:0] dpy;
  logic signed [DIFF_BITS-1:0] dax;
  logic signed [DIFF_BITS-1:0] day;
  logic signed [PROD_BITS-1:0] prod_a;
  logic signed [PROD_BITS-1:0] prod_b;

  assign dpx = $signed({px[COORD_BITS-1], px}) - $signed({bx[COORD_BITS-1], bx});
  assign dpy = $signed({py[COORD_BITS-1], py}) - $signed({by[COORD_BITS-1], by});
  assign dax = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
  assign day = $signed({ay[COORD_BITS-1], ay}) - $signed({by[COORD_BITS-1], by});

  assign prod_a = dpx * day;
  assign prod_b = dax * dpy;

  // edge value is prod_a - prod_b
  assign neg = (prod_a < prod_b);

endmodule

`default_nettype wire

@@ rtl/core/trb_setup.sv @@
// Bounding-box setup from the three vertices of a start request.
`default_nettype none

module trb_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0]          vx [3],
  input  logic signed [COORD_BITS-1:0]          vy [3],
  input  logic [trb_pkg::WIDTH_BITS-1:0]        image_width,
  output logic signed [COORD_BITS-1:0]          lo_x,
  output logic signed [COORD_BITS-1:0]          hi_x,
  output logic signed [COORD_BITS-1:0]          lo_y,
  output logic signed [COORD_BITS-1:0]          hi_y,
  output logic                                  active
);

  localparam int BOX_BITS =
    ((COORD_BITS > trb_pkg::WIDTH_BITS) ? COORD_BITS : trb_pkg::WIDTH_BITS) + 1;

  logic signed [BOX_BITS-1:0] lx;
  logic signed [BOX_BITS-1:0] hx;
  logic signed [BOX_BITS-1:0] ly;
  logic signed [BOX_BITS-1:0] hy;
  logic signed [BOX_BITS-1:0] ex;
  logic signed [BOX_BITS-1:0] ey;

  always_comb begin
    lx = $signed({{(BOX_BITS-trb_pkg::WIDTH_BITS){1'b0}}, image_width});
    ly = lx;
    hx = '0;
    hy = '0;
    ex = '0;
    ey = '0;
    for (int i = 0; i < 3; i++) begin
      ex = $signed({{(BOX_BITS-COORD_BITS){vx[i][COORD_BITS-1]}}, vx[i]});
      ey = $signed({{(BOX_BITS-COORD_BITS){vy[i][COORD_BITS-1]}}, vy[i]});
      if (ex < lx) begin
        lx = ex;
      end
      if (ey < ly) begin
        ly = ey;
      end
      if (ex > hx) begin
        hx = ex;
      end
      if (ey > hy) begin
        hy = ey;
      end
    end
  end

  // an active box always fits the coordinate range
  assign lo_x   = lx[COORD_BITS-1:0];
  assign hi_x   = hx[COORD_BITS-1:0];
  assign lo_y   = ly[COORD_BITS-1:0];
  assign hi_y   = hy[COORD_BITS-1:0];
  assign active = (lx < hx) && (ly < hy);

endmodule

`default_nettype wire

@@ rtl/core/triangle_bbox_rasterizer.sv @@
// Top level of the triangle bounding-box rasterizer.
// A start request (command 0) loads three vertices and a shade and arms a
// column-major scan of the triangle's bounding box; it produces no result.
// Each step request (command 1) while a scan is armed yields one pixel with
// its coverage flag, the shade and a last flag; a step with no armed scan is
// dropped. One request is taken every clock while in_ready is high; a pixel
// appears in the cycle after its step request, edge multipliers and scan counters
// working in a single stage ahead of the output register. Requests keep flowing
// while a result waits, as long as the output register frees in the same cycle.
`default_nettype none

module triangle_bbox_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [trb_pkg::WIDTH_BITS-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [0:0]                            command,
  input  logic signed [COORD_BITS-1:0]          first_x,
  input  logic signed [COORD_BITS-1:0]          first_y,
  input  logic signed [COORD_BITS-1:0]          second_x,
  input  logic signed [COORD_BITS-1:0]          second_y,
  input  logic signed [COORD_BITS-1:0]          third_x,
  input  logic signed [COORD_BITS-1:0]          third_y,
  input  logic [trb_pkg::SHADE_BITS-1:0]        shade_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_BITS-1:0]          pixel_x,
  output logic signed [COORD_BITS-1:0]          pixel_y,
  output logic                                  covered,
  output logic [trb_pkg::SHADE_BITS-1:0]        shade_out,
  output logic                                  last
);

  logic [trb_pkg::WIDTH_BITS-1:0] image_width;
  logic signed [COORD_BITS-1:0]   vx [3];
  logic signed [COORD_BITS-1:0]   vy [3];
  logic [trb_pkg::SHADE_BITS-1:0] fill_shade;
  logic signed [COORD_BITS-1:0]   lo_y;
  logic signed [COORD_BITS-1:0]   hi_x;
  logic signed [COORD_BITS-1:0]   hi_y;
  logic signed [COORD_BITS-1:0]   scan_x;
  logic signed [COORD_BITS-1:0]   scan_y;
  logic                           scan_active;

  logic signed [COORD_BITS-1:0]   in_vx [3];
  logic signed [COORD_BITS-1:0]   in_vy [3];
  logic signed [COORD_BITS-1:0]   new_lo_x;
  logic signed [COORD_BITS-1:0]   new_hi_x;
  logic signed [COORD_BITS-1:0]   new_lo_y;
  logic signed [COORD_BITS-1:0]   new_hi_y;
  logic                           new_active;

  logic [2:0]                     edge_neg;
  logic                           in_fire;
  logic                           is_start;
  logic                           is_step;
  logic                           fin;
  logic                           y_more;
  logic signed [COORD_BITS:0]     scan_x_w;
  logic signed [COORD_BITS:0]     scan_y_w;
  logic signed [COORD_BITS:0]     hi_x_w;
  logic signed [COORD_BITS:0]     hi_y_w;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_start = in_fire && (command == trb_pkg::CMD_START);
  assign is_step  = in_fire && (command == trb_pkg::CMD_STEP) && scan_active;

  assign in_vx[0] = first_x;
  assign in_vx[1] = second_x;
  assign in_vx[2] = third_x;
  assign in_vy[0] = first_y;
  assign in_vy[1] = second_y;
  assign in_vy[2] = third_y;

  trb_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .vx         (in_vx),
    .vy         (in_vy),
    .image_width(image_width),
    .lo_x       (new_lo_x),
    .hi_x       (new_hi_x),
    .lo_y       (new_lo_y),
    .hi_y       (new_hi_y),
    .active     (new_active)
  );

  for (genvar e = 0; e < 3; e++) begin : g_edge
    trb_edge #(
      .COORD_BITS(COORD_BITS)
    ) u_edge (
      .px (scan_x),
      .py (scan_y),
      .ax (vx[e]),
      .ay (vy[e]),
      .bx (vx[(e + 1) % 3]),
      .by (vy[(e + 1) % 3]),
      .neg(edge_neg[e])
    );
  end

  assign scan_x_w = $signed({scan_x[COORD_BITS-1], scan_x});
  assign scan_y_w = $signed({scan_y[COORD_BITS-1], scan_y});
  assign hi_x_w   = $signed({hi_x[COORD_BITS-1], hi_x});
  assign hi_y_w   = $signed({hi_y[COORD_BITS-1], hi_y});
  assign fin      = (scan_x_w == hi_x_w - 1) && (scan_y_w == hi_y_w - 1);
  assign y_more   = (scan_y_w + 1) < hi_y_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= trb_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      image_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
    end else if (is_start) begin
      scan_active <= new_active;
    end else if (is_step && fin) begin
      scan_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_start) begin
      vx         <= in_vx;
      vy         <= in_vy;
      fill_shade <= shade_in;
      hi_x       <= new_hi_x;
      lo_y       <= new_lo_y;
      hi_y       <= new_hi_y;
      scan_x     <= new_lo_x;
      scan_y     <= new_lo_y;
    end else if (is_step && !fin) begin
      if (y_more) begin
        scan_y <= scan_y + 1'b1;
      end else begin
        scan_y <= lo_y;
        scan_x <= scan_x + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_step) begin
      pixel_x   <= scan_x;
      pixel_y   <= scan_y;
      covered   <= (edge_neg[0] == edge_neg[1]) && (edge_neg[1] == edge_neg[2]);
      shade_out <= fill_shade;
      last      <= fin;
    end
  end

`ifndef SYNTH
  a_step_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    is_step |=> out_valid)
    else $error("step on an armed scan gave no pixel");

  a_start_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (is_start && !out_valid) |=> !out_valid)
    else $error("start request produced a pixel");

  a_last_disarms: assert property (@(posedge clk) disable iff (rst)
    (is_step && fin) |=> (!scan_active && last))
    else $error("scan still armed after its last pixel");

  a_scan_in_box: assert property (@(posedge clk) disable iff (rst)
    scan_active |-> ((scan_x < hi_x) && (scan_y < hi_y)))
    else $error("scan position left the box");
`endif

endmodule

`default_nettype wire
